@@ hdl/ufr_pkg.sv @@
`default_nettype none

package ufr_pkg;

    localparam int SET_SIZE = 64;
    localparam int IDX_W    = $clog2(SET_SIZE);
    localparam int ENTRY_W  = IDX_W + 1;
    localparam int ELEM_W   = 6;

    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef logic [ELEM_W-1:0]         elem_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CHASE_A,
        ST_CHASE_B,
        ST_CMP,
        ST_LINK,
        ST_LINK2,
        ST_DONE1,
        ST_DONE0
    } step_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_START,
        C_BAD,
        C_ROOT,
        C_SAME,
        C_TIE
    } cond_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_IN,
        CUR_FOLLOW
    } cur_op_t;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_A,
        CAP_B
    } cap_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_LINK,
        WR_RB_RA
    } wr_op_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_ZERO,
        OUT_ONE
    } out_op_t;

    // one microcode word
    typedef struct packed {
        cond_t   cond;
        step_t   jmp;
        step_t   nxt;
        cur_op_t cur;
        cap_op_t cap;
        wr_op_t  wr;
        out_op_t out;
        logic    idle;
    } ctrl_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic bad;
        logic root;
        logic same;
        logic tie;
    } stat_t;

    // microcode rom: cond true -> jmp, else nxt
    function automatic ctrl_t ucode(step_t s);
        ctrl_t c;
        c = '{cond: C_ALWAYS, jmp: ST_IDLE, nxt: ST_IDLE, cur: CUR_HOLD,
              cap: CAP_NONE, wr: WR_NONE, out: OUT_NONE, idle: 1'b0};
        case (s)
            ST_IDLE:
            begin
                c.cond = C_START;
                c.jmp  = ST_CHECK;
                c.nxt  = ST_IDLE;
                c.cur  = CUR_IN;
                c.idle = 1'b1;
            end
            ST_CHECK:
            begin
                c.cond = C_BAD;
                c.jmp  = ST_DONE0;
                c.nxt  = ST_CHASE_A;
            end
            ST_CHASE_A:
            begin
                c.cond = C_ROOT;
                c.jmp  = ST_CHASE_B;
                c.nxt  = ST_CHASE_A;
                c.cur  = CUR_FOLLOW;
                c.cap  = CAP_A;
            end
            ST_CHASE_B:
            begin
                c.cond = C_ROOT;
                c.jmp  = ST_CMP;
                c.nxt  = ST_CHASE_B;
                c.cur  = CUR_FOLLOW;
                c.cap  = CAP_B;
            end
            ST_CMP:
            begin
                c.cond = C_SAME;
                c.jmp  = ST_DONE0;
                c.nxt  = ST_LINK;
            end
            ST_LINK:
            begin
                c.cond = C_TIE;
                c.jmp  = ST_LINK2;
                c.nxt  = ST_DONE1;
                c.wr   = WR_LINK;
            end
            ST_LINK2:
            begin
                c.jmp = ST_DONE1;
                c.wr  = WR_RB_RA;
            end
            ST_DONE1:
            begin
                c.jmp = ST_IDLE;
                c.out = OUT_ONE;
            end
            ST_DONE0:
            begin
                c.jmp = ST_IDLE;
                c.out = OUT_ZERO;
            end
            default:
            begin
                c.jmp = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/ufr_ram.sv @@
`default_nettype none

module ufr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/ufr_seq.sv @@
`default_nettype none

module ufr_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire ufr_pkg::stat_t stat,
    output ufr_pkg::ctrl_t      ctl,
    output logic                busy
);

    ufr_pkg::step_t step_reg;
    ufr_pkg::step_t step_next;
    logic           cond_true;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ufr_pkg::ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        case (ctl.cond)
            ufr_pkg::C_ALWAYS: cond_true = 1'b1;
            ufr_pkg::C_START:  cond_true = start;
            ufr_pkg::C_BAD:    cond_true = stat.bad;
            ufr_pkg::C_ROOT:   cond_true = stat.root;
            ufr_pkg::C_SAME:   cond_true = stat.same;
            ufr_pkg::C_TIE:    cond_true = stat.tie;
            default:           cond_true = 1'b1;
        endcase
        step_next = cond_true ? ctl.jmp : ctl.nxt;
    end

    always_comb
    begin
        ctl  = ufr_pkg::ucode(step_reg);
        busy = !ctl.idle;
    end

    a_strobe_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out != ufr_pkg::OUT_NONE |=> step_reg == ufr_pkg::ST_IDLE)
        else $error("result strobe not followed by idle");

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        start && ctl.idle |=> step_reg == ufr_pkg::ST_CHECK)
        else $error("accepted request did not enter range check");

    a_merge_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == ufr_pkg::ST_DONE1 |-> $past(ctl.wr) != ufr_pkg::WR_NONE)
        else $error("merge reported without a table write");

endmodule

`default_nettype wire

@@ hdl/ufr_dp.sv @@
`default_nettype none

module ufr_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ufr_pkg::ctrl_t ctl,
    input  wire ufr_pkg::elem_t elem_a,
    input  wire ufr_pkg::elem_t elem_b,
    output ufr_pkg::stat_t      stat,
    output logic                done,
    output logic                merged
);

    ufr_pkg::idx_t   cur_reg;
    ufr_pkg::idx_t   cur_next;
    ufr_pkg::elem_t  b_reg;
    logic            bad_reg;
    ufr_pkg::idx_t   ra_reg;
    ufr_pkg::idx_t   rb_reg;
    ufr_pkg::entry_t va_reg;
    ufr_pkg::entry_t vb_reg;
    logic [ufr_pkg::SET_SIZE-1:0] vld_reg;
    logic            rvld_reg;

    logic [ufr_pkg::ENTRY_W-1:0] rdata;
    ufr_pkg::entry_t entry;
    logic            is_root;
    logic            wr_en;
    ufr_pkg::idx_t   waddr;
    ufr_pkg::entry_t wdata;

    // entries never written read as a rank-zero root
    assign entry   = rvld_reg ? ufr_pkg::entry_t'(rdata) : '1;
    assign is_root = entry[ufr_pkg::ENTRY_W-1]
        || ({1'b0, entry} >= (ufr_pkg::ENTRY_W + 1)'(ufr_pkg::SET_SIZE));

    always_comb
    begin
        case (ctl.cur)
            ufr_pkg::CUR_HOLD:   cur_next = cur_reg;
            ufr_pkg::CUR_IN:     cur_next = ufr_pkg::idx_t'(elem_a);
            ufr_pkg::CUR_FOLLOW: cur_next = is_root ? ufr_pkg::idx_t'(b_reg)
                                                    : entry[ufr_pkg::IDX_W-1:0];
            default:             cur_next = cur_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (ctl.cur == ufr_pkg::CUR_IN)
        begin
            b_reg   <= elem_b;
            bad_reg <= (32'(elem_a) >= ufr_pkg::SET_SIZE)
                    || (32'(elem_b) >= ufr_pkg::SET_SIZE);
        end
        // last capture of a chase lands on the root
        if (ctl.cap == ufr_pkg::CAP_A)
        begin
            ra_reg <= cur_reg;
            va_reg <= entry;
        end
        if (ctl.cap == ufr_pkg::CAP_B)
        begin
            rb_reg <= cur_reg;
            vb_reg <= entry;
        end
    end

    // roots hold -(rank+1): smaller value means higher rank
    always_comb
    begin
        wr_en = 1'b1;
        waddr = ra_reg;
        wdata = ufr_pkg::entry_t'({1'b0, rb_reg});
        case (ctl.wr)
            ufr_pkg::WR_NONE:
            begin
                wr_en = 1'b0;
            end
            ufr_pkg::WR_LINK:
            begin
                if (va_reg < vb_reg)
                begin
                    waddr = rb_reg;
                    wdata = ufr_pkg::entry_t'({1'b0, ra_reg});
                end
                else if (va_reg > vb_reg)
                begin
                    waddr = ra_reg;
                    wdata = ufr_pkg::entry_t'({1'b0, rb_reg});
                end
                else
                begin
                    waddr = ra_reg;
                    wdata = va_reg - ufr_pkg::entry_t'(1);
                end
            end
            ufr_pkg::WR_RB_RA:
            begin
                waddr = rb_reg;
                wdata = ufr_pkg::entry_t'({1'b0, ra_reg});
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rvld_reg <= vld_reg[cur_next];
        end
    end

    ufr_ram #(
        .WIDTH(ufr_pkg::ENTRY_W),
        .DEPTH(ufr_pkg::SET_SIZE)
    ) u_table (
        .clk  (clk),
        .we   (wr_en),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(cur_next),
        .rdata(rdata)
    );

    always_comb
    begin
        stat.bad  = bad_reg;
        stat.root = is_root;
        stat.same = (ra_reg == rb_reg);
        stat.tie  = (va_reg == vb_reg);
        done      = (ctl.out != ufr_pkg::OUT_NONE);
        merged    = (ctl.out == ufr_pkg::OUT_ONE);
    end

    a_no_self_link: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !(!wdata[ufr_pkg::ENTRY_W-1] && wdata[ufr_pkg::IDX_W-1:0] == waddr))
        else $error("table write links an element to itself");

endmodule

`default_nettype wire

@@ hdl/union_find_by_rank.sv @@
`default_nettype none

// Disjoint-set union by rank over a 64-entry parent table, no path compression.
// A request (elem_a, elem_b) is taken at a clock edge where start is high and
// busy is low; exactly one result follows, shown on merged while done is high
// for a single cycle, and the receiver cannot stall it. A small microcode
// sequencer walks parent links one per cycle, since the registered table read
// supplies the next address. A merging request writes the table once, or twice
// on a rank tie, before its result strobe, and a request whose elements already
// share a root writes nothing. The link count from each element to its root is
// at most log2 of the table size; an out-of-range index ends the request with
// merged low, and the block is ready again the cycle after the strobe. The table
// reads as all rank-zero roots right after reset, with no clearing pass.

module union_find_by_rank (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire ufr_pkg::elem_t elem_a,
    input  wire ufr_pkg::elem_t elem_b,
    output logic                busy,
    output logic                done,
    output logic                merged
);

    ufr_pkg::ctrl_t ctl;
    ufr_pkg::stat_t stat;

    ufr_seq u_seq (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .stat (stat),
        .ctl  (ctl),
        .busy (busy)
    );

    ufr_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .elem_a(elem_a),
        .elem_b(elem_b),
        .stat  (stat),
        .done  (done),
        .merged(merged)
    );

endmodule

`default_nettype wire
